// ----- src/lssu_pkg.sv -----
package lssu_pkg;

	// register indexes on the configuration channel
	localparam logic [2:0] RegDistMax    = 3'd0;
	localparam logic [2:0] RegDistMin    = 3'd1;
	localparam logic [2:0] RegAngleStart = 3'd2;
	localparam logic [2:0] RegAngleStep  = 3'd3;
	localparam logic [2:0] RegScanCount  = 3'd4;

	localparam logic [15:0]        DistMaxRst    = 16'd1000;
	localparam logic [15:0]        DistMinRst    = 16'd400;
	localparam logic signed [18:0] AngleStartRst = -19'sd135000;
	localparam logic [13:0]        AngleStepRst  = 14'd250;
	localparam logic [10:0]        ScanCountRst  = 11'd0;

	localparam int unsigned CordicSteps = 20;
	localparam int unsigned LimbW       = 32;
	localparam int unsigned MulW        = 18;

	localparam logic signed [24:0] Q16Deg90  = 25'sd5898240;
	localparam logic signed [24:0] Q16Deg180 = 25'sd11796480;
	localparam logic [MulW-1:0]    FactorOne2 = 18'd131072;   // twice 1.0 in Q2.16
	localparam logic [MulW-1:0]    GeoHiInit  = 18'd131072;

	typedef enum logic [1:0] {
		BIG_INIT,
		BIG_MUL,
		BIG_CMP
	} big_op_t;

	typedef struct packed {
		logic            start;
		big_op_t         op;
		logic            sel_p;   // 1: power register, 0: product register
		logic [MulW-1:0] k;
	} big_req_t;

	typedef struct packed {
		logic done;
		logic le;                 // power <= product
	} big_rsp_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [15:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	// atan(2^-i) in Q16 degrees
	function automatic logic [22:0] atan_q16(input logic [4:0] i);
		logic [22:0] v;
		case (i)
			5'd0:  v = 23'd2949120;
			5'd1:  v = 23'd1740967;
			5'd2:  v = 23'd919879;
			5'd3:  v = 23'd466945;
			5'd4:  v = 23'd234379;
			5'd5:  v = 23'd117304;
			5'd6:  v = 23'd58666;
			5'd7:  v = 23'd29335;
			5'd8:  v = 23'd14668;
			5'd9:  v = 23'd7334;
			5'd10: v = 23'd3667;
			5'd11: v = 23'd1833;
			5'd12: v = 23'd917;
			5'd13: v = 23'd458;
			5'd14: v = 23'd229;
			5'd15: v = 23'd115;
			5'd16: v = 23'd57;
			5'd17: v = 23'd29;
			5'd18: v = 23'd14;
			5'd19: v = 23'd7;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- src/laser_sector_avoidance_scale_unit.sv -----
// Channel  Dir  Handshake                Payload
// -------  ---  -----------------------  ------------------------------------------
// s_       in   s_tvalid / s_tready      s_tuser: kind; s_tdata: index, range, x, y
// m_       out  m_tvalid / m_tready      m_tdata: speed_scale, samples_used
// cfg_     in   cfg_valid / cfg_ready    cfg_index, cfg_data (always ready)
//
// Store transaction: accepted while idle, s_tready stays high.
// Query: CORDIC vectoring, up to two sector end divides and a product
//   init, then per sample up to one divide and one limb-serial multiply,
//   then up to 18 bisection rounds of a power init, n multiplies and a
//   compare. The multi-limb registers in lssu_big hold L limbs, L being
//   22 by default.
// s_tready is low from query acceptance until the result is loaded into the
//   output register; a stalled m_ side holds the block in its output state.
// Reset clears control and loads the configuration defaults; the range store starts undefined.
module laser_sector_avoidance_scale_unit #(
	parameter int unsigned SCAN_DEPTH      = 1024,
	parameter int unsigned SAMPLE_STRIDE   = 27,
	parameter int unsigned HALF_SECTOR_DEG = 45
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,     // sample_index[9:0], sample_range_mm[25:10],
	                                 // query_x_mm[49:26], query_y_mm[73:50], zero pad
	input  logic        s_tuser,     // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,     // speed_scale[16:0], samples_used[23:17]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [18:0] cfg_data
);

	localparam int unsigned IdxW     = $clog2(SCAN_DEPTH);
	localparam int unsigned CntW     = $clog2(SCAN_DEPTH + 1);
	localparam int unsigned MaxTerms = (SCAN_DEPTH - 1) / SAMPLE_STRIDE + 1;
	localparam int unsigned NW       = $clog2(MaxTerms + 1);
	localparam int unsigned Limbs    = (17 * MaxTerms) / 32 + 2;
	localparam int unsigned PosW     = IdxW + 7;
	localparam int unsigned K        = lssu_pkg::MulW;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CORDIC,
		S_SECT,
		S_SECT_W,
		S_GATH,
		S_FAC,
		S_FAC_W,
		S_BS,
		S_PMUL,
		S_CMP,
		S_BIG_W,
		S_OUT
	} state_t;

	// configuration
	logic [15:0]        dmax_q;
	logic [15:0]        dmin_q;
	logic signed [18:0] astart_q;
	logic [13:0]        astep_q;
	logic [10:0]        scount_q;

	// control and working registers
	state_t             st_q;
	state_t             ret_q;
	logic signed [23:0] x_q;
	logic signed [23:0] y_q;
	logic [CntW-1:0]    cnt_q;
	logic [25:0]        vx_q;
	logic signed [26:0] vy_q;
	logic signed [24:0] z_q;
	logic [4:0]         it_q;
	logic signed [8:0]  hdg_q;
	logic               hi_sel_q;
	logic [IdxW-1:0]    lo_idx_q;
	logic [IdxW-1:0]    hi_idx_q;
	logic [PosW-1:0]    pos_q;
	logic [NW-1:0]      n_q;
	logic [NW-1:0]      j_q;
	logic               zero_q;
	logic [K-1:0]       blo_q;
	logic [K-1:0]       bhi_q;
	logic [K-1:0]       mid_q;
	logic [16:0]        res_scale_q;
	logic [6:0]         res_n_q;
	logic               m_tvalid_q;
	logic [23:0]        m_tdata_q;

	lssu_pkg::big_req_t big_req_q;
	lssu_pkg::big_rsp_t big_rsp;
	lssu_pkg::div_req_t div_req_q;
	lssu_pkg::div_rsp_t div_rsp;

	// range store
	logic [15:0]        rng_mem [SCAN_DEPTH];
	logic [15:0]        rng_rd_q;

	// input unpacking
	logic               in_kind;
	logic [9:0]         in_idx;
	logic [15:0]        in_range;
	logic signed [23:0] in_x;
	logic signed [23:0] in_y;
	logic               acc;
	logic [IdxW+9:0]    idx_ext;
	logic               st_we;
	logic [CntW-1:0]    cnt_now;
	logic [24:0]        x_abs;
	logic [24:0]        y_abs;

	assign in_kind  = s_tuser;
	assign in_idx   = s_tdata[9:0];
	assign in_range = s_tdata[25:10];
	assign in_x     = s_tdata[49:26];
	assign in_y     = s_tdata[73:50];
	assign s_tready = (st_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign idx_ext  = {{IdxW{1'b0}}, in_idx};
	assign st_we    = acc && !in_kind && (idx_ext < (IdxW+10)'(SCAN_DEPTH));
	assign cnt_now  = ({21'd0, scount_q} > SCAN_DEPTH) ? CntW'(SCAN_DEPTH) : CntW'(scount_q);
	assign x_abs    = in_x[23] ? 25'(-{in_x[23], in_x}) : {1'b0, in_x};
	assign y_abs    = in_y[23] ? 25'(-{in_y[23], in_y}) : {1'b0, in_y};

	always_ff @(posedge clk) begin
		if (st_we)
			rng_mem[idx_ext[IdxW-1:0]] <= in_range;
		rng_rd_q <= rng_mem[pos_q[IdxW-1:0]];
	end

	// one CORDIC vectoring step; shifts of a negative residue round toward zero
	logic [25:0]        sx;
	logic [26:0]        vy_abs;
	logic [26:0]        sy_m;
	logic signed [24:0] at;
	logic [25:0]        vx_n;
	logic signed [26:0] vy_n;
	logic signed [24:0] z_n;
	logic signed [24:0] z_cl;
	logic signed [24:0] ang;
	logic [7:0]         mag;
	logic signed [8:0]  hdg_fin;

	always_comb begin
		sx     = vx_q >> it_q;
		vy_abs = vy_q[26] ? 27'(-vy_q) : 27'(vy_q);
		sy_m   = vy_abs >> it_q;
		at     = signed'({2'b00, lssu_pkg::atan_q16(it_q)});
		vx_n   = vx_q + sy_m[25:0];
		if (!vy_q[26]) begin
			vy_n = vy_q - signed'({1'b0, sx});
			z_n  = z_q + at;
		end else begin
			vy_n = vy_q + signed'({1'b0, sx});
			z_n  = z_q - at;
		end
		z_cl = z_q;
		if (z_q < 0)
			z_cl = '0;
		else if (z_q > lssu_pkg::Q16Deg90)
			z_cl = lssu_pkg::Q16Deg90;
		ang     = x_q[23] ? (lssu_pkg::Q16Deg180 - z_cl) : z_cl;
		mag     = ang[23:16];
		hdg_fin = y_q[23] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
	end

	// sector end index numerator: 1000*t - start
	logic signed [9:0]  t_deg;
	logic signed [20:0] num;
	logic [15:0]        div_step;
	logic [CntW-1:0]    cnt_m1;
	logic [IdxW-1:0]    idx_cap;

	always_comb begin
		t_deg    = hi_sel_q ? (10'(hdg_q) + 10'(HALF_SECTOR_DEG))
		                    : (10'(hdg_q) - 10'(HALF_SECTOR_DEG));
		num      = 21'(t_deg) * 21'sd1000 - 21'(astart_q);
		div_step = (astep_q == '0) ? 16'd1 : {2'b00, astep_q};
		cnt_m1   = cnt_q - CntW'(1);
		idx_cap  = (div_rsp.quotient > 32'(cnt_m1)) ? cnt_m1[IdxW-1:0]
		                                            : div_rsp.quotient[IdxW-1:0];
	end

	// factor and bisection helpers
	logic [15:0]     rng;
	logic [16:0]     fq;
	logic [K-1:0]    mid_c;
	logic [K-1:0]    bsum;
	logic [PosW-1:0] pos_nx;

	assign rng    = rng_rd_q;
	assign fq     = div_rsp.quotient[16:0];
	assign mid_c  = blo_q + ((bhi_q - blo_q + K'(1)) >> 1);
	assign bsum   = blo_q + K'(1);
	assign pos_nx = pos_q + PosW'(SAMPLE_STRIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmax_q      <= lssu_pkg::DistMaxRst;
			dmin_q      <= lssu_pkg::DistMinRst;
			astart_q    <= lssu_pkg::AngleStartRst;
			astep_q     <= lssu_pkg::AngleStepRst;
			scount_q    <= lssu_pkg::ScanCountRst;
			st_q        <= S_IDLE;
			ret_q       <= S_IDLE;
			x_q         <= '0;
			y_q         <= '0;
			cnt_q       <= '0;
			vx_q        <= '0;
			vy_q        <= '0;
			z_q         <= '0;
			it_q        <= '0;
			hdg_q       <= '0;
			hi_sel_q    <= 1'b0;
			lo_idx_q    <= '0;
			hi_idx_q    <= '0;
			pos_q       <= '0;
			n_q         <= '0;
			j_q         <= '0;
			zero_q      <= 1'b0;
			blo_q       <= '0;
			bhi_q       <= '0;
			mid_q       <= '0;
			res_scale_q <= '0;
			res_n_q     <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
			big_req_q   <= '0;
			div_req_q   <= '0;
		end else begin
			big_req_q.start <= 1'b0;
			div_req_q.start <= 1'b0;
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;

			if (cfg_valid) begin
				unique case (cfg_index)
					lssu_pkg::RegDistMax:    dmax_q   <= cfg_data[15:0];
					lssu_pkg::RegDistMin:    dmin_q   <= cfg_data[15:0];
					lssu_pkg::RegAngleStart: astart_q <= signed'(cfg_data);
					lssu_pkg::RegAngleStep:  astep_q  <= cfg_data[13:0];
					lssu_pkg::RegScanCount:  scount_q <= cfg_data[10:0];
					default: ;
				endcase
			end

			unique case (st_q)
				S_IDLE: begin
					if (acc && in_kind) begin
						x_q         <= in_x;
						y_q         <= in_y;
						cnt_q       <= cnt_now;
						res_scale_q <= '0;
						res_n_q     <= '0;
						hi_sel_q    <= 1'b0;
						if (cnt_now == '0) begin
							st_q <= S_OUT;              // no scan
						end else if (in_x == '0) begin
							// on the y axis, or the origin
							if (in_y == '0)
								hdg_q <= 9'sd0;
							else
								hdg_q <= in_y[23] ? -9'sd90 : 9'sd90;
							st_q <= S_SECT;
						end else begin
							vx_q <= {1'b0, x_abs};
							vy_q <= signed'({2'b00, y_abs});
							z_q  <= '0;
							it_q <= '0;
							st_q <= S_CORDIC;
						end
					end
				end

				S_CORDIC: begin
					if ((it_q == 5'(lssu_pkg::CordicSteps)) || (vy_q == '0)) begin
						hdg_q <= hdg_fin;
						st_q  <= (mag > 8'd90) ? S_OUT : S_SECT;   // behind: reject
					end else begin
						vx_q <= vx_n;
						vy_q <= vy_n;
						z_q  <= z_n;
						it_q <= it_q + 5'd1;
					end
				end

				S_SECT: begin
					if (num < 0) begin
						// sector end before sample zero
						if (!hi_sel_q) begin
							lo_idx_q <= '0;
							hi_sel_q <= 1'b1;
							st_q     <= S_SECT;
						end else begin
							hi_idx_q  <= '0;
							big_req_q <= '{start: 1'b1, op: lssu_pkg::BIG_INIT,
							               sel_p: 1'b0, k: '0};
							pos_q     <= PosW'(lo_idx_q);
							n_q       <= '0;
							zero_q    <= 1'b0;
							ret_q     <= S_GATH;
							st_q      <= S_BIG_W;
						end
					end else begin
						div_req_q <= '{start: 1'b1, dividend: 32'(num[19:0]),
						               divisor: div_step};
						st_q      <= S_SECT_W;
					end
				end

				S_SECT_W: begin
					if (div_rsp.done) begin
						if (!hi_sel_q) begin
							lo_idx_q <= idx_cap;
							hi_sel_q <= 1'b1;
							st_q     <= S_SECT;
						end else begin
							hi_idx_q  <= idx_cap;
							big_req_q <= '{start: 1'b1, op: lssu_pkg::BIG_INIT,
							               sel_p: 1'b0, k: '0};
							pos_q     <= PosW'(lo_idx_q);
							n_q       <= '0;
							zero_q    <= 1'b0;
							ret_q     <= S_GATH;
							st_q      <= S_BIG_W;
						end
					end
				end

				S_GATH: begin
					// range read of rng_mem[pos] lands in rng_rd_q at this edge
					if ((pos_q <= PosW'(hi_idx_q)) && (n_q < NW'(MaxTerms))) begin
						st_q <= S_FAC;
					end else if ((n_q == '0) || zero_q) begin
						res_n_q <= 7'(n_q);
						st_q    <= S_OUT;
					end else begin
						blo_q <= '0;
						bhi_q <= lssu_pkg::GeoHiInit;
						st_q  <= S_BS;
					end
				end

				S_FAC: begin
					if (rng >= dmax_q) begin
						n_q   <= n_q + NW'(1);
						pos_q <= pos_nx;
						if (!zero_q) begin
							big_req_q <= '{start: 1'b1, op: lssu_pkg::BIG_MUL,
							               sel_p: 1'b0, k: lssu_pkg::FactorOne2};
							ret_q     <= S_GATH;
							st_q      <= S_BIG_W;
						end else begin
							st_q <= S_GATH;
						end
					end else if (rng <= dmin_q) begin
						zero_q <= 1'b1;
						n_q    <= n_q + NW'(1);
						pos_q  <= pos_nx;
						st_q   <= S_GATH;
					end else begin
						div_req_q <= '{start: 1'b1, dividend: {rng - dmin_q, 16'd0},
						               divisor: dmax_q - dmin_q};
						st_q      <= S_FAC_W;
					end
				end

				S_FAC_W: begin
					if (div_rsp.done) begin
						n_q   <= n_q + NW'(1);
						pos_q <= pos_nx;
						if (zero_q || (fq == '0)) begin
							zero_q <= 1'b1;
							st_q   <= S_GATH;
						end else begin
							big_req_q <= '{start: 1'b1, op: lssu_pkg::BIG_MUL,
							               sel_p: 1'b0, k: {fq, 1'b0}};
							ret_q     <= S_GATH;
							st_q      <= S_BIG_W;
						end
					end
				end

				S_BS: begin
					// bisection on m with m^n <= product of 2f
					if (blo_q < bhi_q) begin
						mid_q     <= mid_c;
						j_q       <= '0;
						big_req_q <= '{start: 1'b1, op: lssu_pkg::BIG_INIT,
						               sel_p: 1'b1, k: '0};
						ret_q     <= S_PMUL;
						st_q      <= S_BIG_W;
					end else begin
						res_scale_q <= bsum[K-1:1];
						res_n_q     <= 7'(n_q);
						st_q        <= S_OUT;
					end
				end

				S_PMUL: begin
					if (j_q < n_q) begin
						j_q       <= j_q + NW'(1);
						big_req_q <= '{start: 1'b1, op: lssu_pkg::BIG_MUL,
						               sel_p: 1'b1, k: mid_q};
						ret_q     <= S_PMUL;
					end else begin
						big_req_q <= '{start: 1'b1, op: lssu_pkg::BIG_CMP,
						               sel_p: 1'b1, k: '0};
						ret_q     <= S_CMP;
					end
					st_q <= S_BIG_W;
				end

				S_CMP: begin
					if (big_rsp.le)
						blo_q <= mid_q;
					else
						bhi_q <= mid_q - K'(1);
					st_q <= S_BS;
				end

				S_BIG_W: begin
					if (big_rsp.done)
						st_q <= ret_q;
				end

				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {res_n_q, res_scale_q};
						st_q       <= S_IDLE;
					end
				end

				default: st_q <= S_IDLE;
			endcase
		end
	end

	lssu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	lssu_big #(
		.Limbs (Limbs)
	) u_big (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (big_req_q),
		.rsp    (big_rsp)
	);

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

endmodule

// ----- src/lssu_div.sv -----
// restoring divider, one quotient bit per cycle
module lssu_div (
	input  logic                clk,
	input  logic                arst_n,
	input  lssu_pkg::div_req_t  req,
	output lssu_pkg::div_rsp_t  rsp
);

	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic [16:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// rem < divisor keeps trial below 2^17, so bit 16 is the borrow
			if (!diff[16]) begin
				rem_q <= diff[15:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- src/lssu_big.sv -----
// two multi-limb registers held in memories: init to one, multiply by a
// small factor limb by limb, compare from the top limb down
module lssu_big #(
	parameter int unsigned Limbs = 22
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lssu_pkg::big_req_t  req,
	output lssu_pkg::big_rsp_t  rsp
);

	localparam int unsigned AW = (Limbs > 1) ? $clog2(Limbs) : 1;
	localparam logic [AW-1:0] LastLimb = AW'(Limbs - 1);
	localparam int unsigned W = lssu_pkg::LimbW;
	localparam int unsigned K = lssu_pkg::MulW;

	typedef enum logic [2:0] {
		B_IDLE,
		B_INIT,
		B_MRD,
		B_MMP,
		B_MAD,
		B_CRD,
		B_CEV
	} bstate_t;

	bstate_t        st_q;
	logic [W-1:0]   mem_p [Limbs];
	logic [W-1:0]   mem_q [Limbs];
	logic [W-1:0]   rdp_q;
	logic [W-1:0]   rdq_q;
	logic [AW-1:0]  ptr_q;
	logic           sel_q;
	logic [K-1:0]   k_q;
	logic [W+K-1:0] prod_q;
	logic [K-1:0]   carry_q;
	logic           dec_q;
	logic           lt_q;
	logic           done_q;
	logic           le_q;

	logic [W+K:0]   sum;
	logic [W-1:0]   rd_sel;
	logic           we;
	logic [W-1:0]   wdata;

	assign sum    = {1'b0, prod_q} + {{(W+1){1'b0}}, carry_q};
	assign rd_sel = sel_q ? rdp_q : rdq_q;

	always_comb begin
		we    = (st_q == B_INIT) || (st_q == B_MAD);
		wdata = sum[W-1:0];
		if (st_q == B_INIT)
			wdata = (ptr_q == '0) ? W'(1) : '0;
	end

	always_ff @(posedge clk) begin
		if (we && sel_q)
			mem_p[ptr_q] <= wdata;
		if (we && !sel_q)
			mem_q[ptr_q] <= wdata;
		rdp_q <= mem_p[ptr_q];
		rdq_q <= mem_q[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= B_IDLE;
			ptr_q   <= '0;
			sel_q   <= 1'b0;
			k_q     <= '0;
			prod_q  <= '0;
			carry_q <= '0;
			dec_q   <= 1'b0;
			lt_q    <= 1'b0;
			done_q  <= 1'b0;
			le_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					if (req.start) begin
						sel_q   <= req.sel_p;
						k_q     <= req.k;
						carry_q <= '0;
						dec_q   <= 1'b0;
						lt_q    <= 1'b0;
						unique case (req.op)
							lssu_pkg::BIG_INIT: begin
								ptr_q <= '0;
								st_q  <= B_INIT;
							end
							lssu_pkg::BIG_MUL: begin
								ptr_q <= '0;
								st_q  <= B_MRD;
							end
							lssu_pkg::BIG_CMP: begin
								ptr_q <= LastLimb;
								st_q  <= B_CRD;
							end
							default: st_q <= B_IDLE;
						endcase
					end
				end
				B_INIT: begin
					if (ptr_q == LastLimb) begin
						done_q <= 1'b1;
						st_q   <= B_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				B_MRD: st_q <= B_MMP;
				B_MMP: begin
					prod_q <= rd_sel * k_q;
					st_q   <= B_MAD;
				end
				B_MAD: begin
					carry_q <= sum[W+K-1:W];
					if (ptr_q == LastLimb) begin
						done_q <= 1'b1;
						st_q   <= B_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
						st_q  <= B_MRD;
					end
				end
				B_CRD: st_q <= B_CEV;
				B_CEV: begin
					if (!dec_q && (rdp_q != rdq_q)) begin
						dec_q <= 1'b1;
						lt_q  <= rdp_q < rdq_q;
					end
					if (ptr_q == '0) begin
						if (dec_q)
							le_q <= lt_q;
						else
							le_q <= (rdp_q != rdq_q) ? (rdp_q < rdq_q) : 1'b1;
						done_q <= 1'b1;
						st_q   <= B_IDLE;
					end else begin
						ptr_q <= ptr_q - AW'(1);
						st_q  <= B_CRD;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.le   = le_q;

endmodule

// ----- verif/lssu_scoreboard.sv -----
`timescale 1ns / 1ps

// Watches the input, result and register channels of the scale unit, predicts
// each query result and compares it with what comes out.
module lssu_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [18:0] cfg_data,
	output int          fails,
	output int          pending
);

	localparam int Depth     = 1024;
	localparam int Stride    = 27;
	localparam int HalfDeg   = 45;
	localparam int MaxTerms  = (Depth - 1) / Stride + 1;
	localparam int KindQuery = 1;

	typedef logic [831:0] wide_t;

	typedef struct packed {
		logic [16:0] scale;
		logic [6:0]  used;
	} scale_res_t;

	localparam longint AtanQ16 [20] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335, 14668, 7334,
		3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
	};

	logic [15:0]        ranges [Depth];
	logic [15:0]        far_mm, near_mm;
	logic signed [18:0] start_mdeg;
	logic [13:0]        step_mdeg;
	logic [10:0]        scan_len;
	scale_res_t         scale_q [$];

	function automatic longint shr_tz(longint v, int s);
		return (v >= 0) ? (v >>> s) : -((-v) >>> s);
	endfunction

	// heading in whole degrees, CORDIC vectoring in Q16 degrees
	function automatic int heading_of(longint x, longint y);
		longint ax, ay, vx, vy, z, nx, ang;
		int mag;
		if (x == 0)
			return (y == 0) ? 0 : ((y < 0) ? -90 : 90);
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		z  = 0;
		if (ay != 0) begin
			vx = ax;
			vy = ay;
			for (int i = 0; i < 20; i++) begin
				if (vy == 0)
					break;
				if (vy > 0) begin
					nx = vx + shr_tz(vy, i);
					vy = vy - shr_tz(vx, i);
					z  = z + AtanQ16[i];
				end else begin
					nx = vx - shr_tz(vy, i);
					vy = vy + shr_tz(vx, i);
					z  = z - AtanQ16[i];
				end
				vx = nx;
			end
			if (z < 0)
				z = 0;
			if (z > 90 * 65536)
				z = 90 * 65536;
		end
		ang = (x > 0) ? z : 180 * 65536 - z;
		mag = int'(ang >>> 16);
		return (y < 0) ? -mag : mag;
	endfunction

	function automatic int sector_of(int deg, int cnt);
		longint num, stp, idx;
		num = longint'(deg) * 1000 - longint'(start_mdeg);
		stp = (step_mdeg == 0) ? 1 : longint'(step_mdeg);
		idx = (num < 0) ? 0 : num / stp;
		if (idx > cnt - 1)
			idx = cnt - 1;
		return int'(idx);
	endfunction

	function automatic longint factor_of(logic [15:0] r);
		if (r >= far_mm)
			return 65536;
		if (r <= near_mm)
			return 0;
		return ((longint'(r) - longint'(near_mm)) << 16) /
			(longint'(far_mm) - longint'(near_mm));
	endfunction

	// largest m with m^n <= product of 2f, then m/2 rounded half up; exact in wide integers
	function automatic longint geo_mean(longint f [$]);
		wide_t  prod, pw;
		longint lo, hi, mid;
		prod = 1;
		foreach (f[i])
			prod = prod * wide_t'(2 * f[i]);
		lo = 0;
		hi = 131072;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			pw  = 1;
			foreach (f[i])
				pw = pw * wide_t'(mid);
			if (pw <= prod)
				lo = mid;
			else
				hi = mid - 1;
		end
		return (lo + 1) >> 1;
	endfunction

	function automatic scale_res_t predict_scale(longint x, longint y);
		scale_res_t res;
		longint     facs [$];
		int         cnt, h, lo, hi;
		bit         any_zero;
		res      = '0;
		any_zero = 0;
		cnt = (scan_len > Depth) ? Depth : int'(scan_len);
		if (cnt == 0)
			return res;
		h = heading_of(x, y);
		if (h < -90 || h > 90)
			return res;
		lo = sector_of(h - HalfDeg, cnt);
		hi = sector_of(h + HalfDeg, cnt);
		for (int i = lo; i <= hi && facs.size() < MaxTerms; i += Stride) begin
			facs.push_back(factor_of(ranges[i]));
			if (facs[$] == 0)
				any_zero = 1;
		end
		res.used = 7'(facs.size());
		if (facs.size() > 0 && !any_zero)
			res.scale = 17'(geo_mean(facs));
		return res;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: scale result %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	initial fails = 0;

	always @(posedge clk or negedge arst_n) begin
		scale_res_t want;
		if (!arst_n) begin
			far_mm     <= lssu_pkg::DistMaxRst;
			near_mm    <= lssu_pkg::DistMinRst;
			start_mdeg <= lssu_pkg::AngleStartRst;
			step_mdeg  <= lssu_pkg::AngleStepRst;
			scan_len   <= lssu_pkg::ScanCountRst;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lssu_pkg::RegDistMax:    far_mm     <= cfg_data[15:0];
					lssu_pkg::RegDistMin:    near_mm    <= cfg_data[15:0];
					lssu_pkg::RegAngleStart: start_mdeg <= cfg_data;
					lssu_pkg::RegAngleStep:  step_mdeg  <= cfg_data[13:0];
					lssu_pkg::RegScanCount:  scan_len   <= cfg_data[10:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == KindQuery)
					scale_q.push_back(predict_scale(longint'($signed(s_tdata[49:26])),
						longint'($signed(s_tdata[73:50]))));
				else
					ranges[s_tdata[9:0]] = s_tdata[25:10];
			end
			if (m_tvalid && m_tready) begin
				if (scale_q.size() == 0) begin
					report("unexpected", 32'(m_tdata), 32'd0);
				end else begin
					want = scale_q.pop_front();
					if (m_tdata[16:0] !== want.scale)
						report("speed_scale", 32'(m_tdata[16:0]), 32'(want.scale));
					if (m_tdata[23:17] !== want.used)
						report("samples_used", 32'(m_tdata[23:17]), 32'(want.used));
				end
			end
			pending <= scale_q.size();
		end
	end

endmodule

// ----- verif/tb_laser_sector_avoidance_scale_unit.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the scale unit. The scoreboard beside the DUT does
// all prediction and comparison; this module makes transactions and reports the verdict.
module tb_laser_sector_avoidance_scale_unit;

	localparam int QuietLimit = 400000;   // watchdog limit on cycles with no transaction
	localparam bit KindStore  = 1'b0;
	localparam bit KindQuery  = 1'b1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;       // index[9:0], range[25:10], x[49:26], y[73:50]
	logic        s_tuser = 1'b0;     // kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;            // speed_scale[16:0], samples_used[23:17]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [18:0] cfg_data = '0;

	int fails, pending;
	int s_idle_pct, m_idle_pct;
	int quiet = 0;
	int near_now, far_now;            // range band used to keep factors interesting

	laser_sector_avoidance_scale_unit dut (.*);

	lssu_scoreboard u_scoreboard (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// receiver: one NBA per edge
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= m_idle_pct);

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QuietLimit) begin
			$display("tb_laser_sector_avoidance_scale_unit: done, errors");
			$finish;
		end
	end

	// one input transaction; tvalid is left high for a following item
	task automatic send(bit kind, int idx, int rng, int x, int y);
		bit ok;
		if ($urandom_range(99) < s_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {6'd0, y[23:0], x[23:0], rng[15:0], idx[9:0]};
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
	endtask

	// drop tvalid and let every pending query drain before touching registers
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, int val);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[18:0];
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
	endtask

	task automatic set_regs(int dmax, int dmin, int start, int step, int cnt);
		reg_write(lssu_pkg::RegDistMax, dmax);
		reg_write(lssu_pkg::RegDistMin, dmin);
		reg_write(lssu_pkg::RegAngleStart, start);
		reg_write(lssu_pkg::RegAngleStep, step);
		reg_write(lssu_pkg::RegScanCount, cnt);
		cfg_valid <= 1'b0;
		@(posedge clk);
		near_now = (dmin < dmax) ? dmin : dmax;
		far_now  = (dmin < dmax) ? dmax : dmin;
	endtask

	function automatic int band_range();
		int lo, hi;
		if ($urandom_range(3) == 0)
			return $urandom_range(65535);
		lo = (near_now > 50) ? near_now - 50 : 0;
		hi = (far_now < 65485) ? far_now + 50 : 65535;
		return $urandom_range(hi, lo);
	endfunction

	// mostly well-formed: stores inside the useful band, queries of every shape
	task automatic random_items(int n, int query_pct);
		int x, y;
		repeat (n) begin
			if ($urandom_range(99) < query_pct) begin
				case ($urandom_range(5))
					0: begin x = $urandom; y = $urandom; end
					1: begin x = $urandom_range(5000, 1); y = $urandom_range(10000) - 5000; end
					2: begin x = 0; y = $urandom; end
					3: begin x = $urandom; y = 0; end
					4: begin x = -$urandom_range(50, 1); y = $urandom_range(8388607, 100000); end
					default: begin x = $urandom_range(8388607, 1); y = $urandom; end
				endcase
				send(KindQuery, $urandom_range(1023), $urandom_range(65535), x, y);
			end else begin
				send(KindStore, $urandom_range(1023), band_range(), $urandom, $urandom);
			end
		end
		drain();
	endtask

	initial begin
		s_idle_pct = 9;
		m_idle_pct = 80;
		near_now   = 400;
		far_now    = 1000;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no scan yet: query is rejected
		send(KindQuery, 0, 0, 100, 0);
		// fill the whole store so no query ever reads an unwritten slot
		for (int i = 0; i < 1024; i++)
			send(KindStore, i, band_range(), $urandom, $urandom);
		send(KindStore, 0, 0, 0, 0);
		send(KindStore, 1023, 65535, 0, 0);
		send(KindStore, 5, 1000, 0, 0);
		drain();

		// directed queries on a typical 0.25 degree scan from -135 degrees
		set_regs(1000, 400, -135000, 250, 1024);
		send(KindQuery, 0, 0, 0, 0);                       // origin
		send(KindQuery, 0, 0, 0, 5);                       // +y axis
		send(KindQuery, 0, 0, 0, -5);                      // -y axis
		send(KindQuery, 0, 0, 7, 0);                       // straight ahead
		send(KindQuery, 0, 0, -7, 0);                      // straight behind, rejected
		send(KindQuery, 1023, 65535, 8388607, 8388607);
		send(KindQuery, 0, 0, -8388608, -8388608);
		send(KindQuery, 0, 0, 8388607, -8388608);
		send(KindQuery, 0, 0, -1, 8388607);                // just past 90
		send(KindQuery, 0, 0, 1, 1);
		send(KindQuery, 0, 0, 3, -4);
		drain();

		random_items(45, 25);

		// coarse steps, full distance span
		set_regs(65535, 0, -180000, 10000, 1024);
		random_items(45, 25);

		// receiver now mostly ready, sender gappy
		s_idle_pct = 80;
		m_idle_pct = 9;
		// inverted limits make a step at max; sector start beyond every heading
		set_regs(300, 800, 180000, 1, 40);
		random_items(45, 25);

		// zero step, oversized count: widest sectors, slow queries kept rare
		set_regs(0, 65535, -180000, 0, 2047);
		random_items(40, 5);

		s_idle_pct = 0;
		m_idle_pct = 0;
		set_regs(2000, 100, -90000, 3000, 200);
		random_items(50, 25);

		set_regs(65535, 65534, 0, 16383, 1);
		random_items(45, 25);

		// back to reset-like values with a short scan
		set_regs(1000, 400, -135000, 250, 64);
		random_items(45, 25);

		set_regs(1000, 400, -135000, 250, 0);
		random_items(10, 50);

		repeat (32) @(posedge clk);
		if (fails == 0)
			$display("tb_laser_sector_avoidance_scale_unit: done, clean");
		else
			$display("tb_laser_sector_avoidance_scale_unit: done, errors");
		$finish;
	end

endmodule
